// ===== hw/rtl/pfa_pkg.sv =====
// Shared constants, codes and types of the partition fit allocator.
package pfa_pkg;

   localparam int MAX_PARTITIONS = 64;
   localparam int SIZE_BITS      = 16;
   localparam int IDX_BITS       = $clog2(MAX_PARTITIONS);
   localparam int CNT_BITS       = $clog2(MAX_PARTITIONS + 1);
   localparam int RAM_W          = 2 * SIZE_BITS;

   localparam int ACTION_W = 2;
   localparam int AMOUNT_W = 16;
   localparam int POLICY_W = 2;
   localparam int KIND_W   = 2;
   localparam int INDEX_W  = 6;
   localparam int SPACE_W  = 16;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_PAD_W   = RSP_TDATA_W - INDEX_W - SPACE_W;
   localparam int RSP_TUSER_W = KIND_W + 1;

   localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REPORT = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

   localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic               success;
      logic [INDEX_W-1:0] index;
      logic [SPACE_W-1:0] space;
      logic               last;
   } rsp_type;

endpackage

// ===== hw/rtl/partition_fit_allocator_top.sv =====
// Top level of the partition fit allocator: policy register, engine and result register.
//
//   channel  direction  tdata                          tuser                  tlast
//   req_     in         amount[15:0]                   action[1:0]            -
//   rsp_     out        partition_index[5:0],          kind[1:0], success[2]  last
//                       space_left[21:6], zero[23:22]
//   csr_     in         fit_policy via csr_wr_data[1:0], written when csr_wr_en is high
//
// Load: one table write while the table has room, and one result. Allocate: a table scan
// at one read per cycle, then the final read drain, then one result.
// Report: one table read per emitted entry. Clear: no results.
// Reset clears the count, the used flags and the policy; table contents stay undefined.
// A stalled result holds in the output register while the next transaction is accepted.
module partition_fit_allocator_top
   import pfa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [AMOUNT_W-1:0]    req_tdata,   // amount
   input  logic [ACTION_W-1:0]    req_tuser,   // action
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // partition_index, space_left, pad
   output logic [RSP_TUSER_W-1:0] rsp_tuser,   // kind, success
   output logic                   rsp_tlast,
   input  logic                   csr_wr_en,
   input  logic [POLICY_W-1:0]    csr_wr_data
);

   logic [POLICY_W-1:0] policy_ff, policy_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_data_ff;
   logic                out_ready;
   logic                push;
   rsp_type             result;

   assign out_ready = !out_valid_ff || rsp_tready;

   pfa_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_action  (req_tuser),
      .in_amount  (req_tdata),
      .fit_policy (policy_ff),
      .out_ready  (out_ready),
      .out_push   (push),
      .out_result (result)
   );

   always_comb begin
      policy_in = csr_wr_en ? csr_wr_data : policy_ff;
      if (push) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POL_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         policy_ff    <= policy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_data_ff.space, out_data_ff.index};
   assign rsp_tuser  = {out_data_ff.success, out_data_ff.kind};
   assign rsp_tlast  = out_data_ff.last;

endmodule

// ===== hw/rtl/pfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pfa_engine.sv =====
// Partition table sequencer: load, clear, fit scan, allocation write-back and report.
module pfa_engine
   import pfa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [ACTION_W-1:0] in_action,
   input  logic [AMOUNT_W-1:0] in_amount,
   input  logic [POLICY_W-1:0] fit_policy,
   input  logic                out_ready,
   output logic                out_push,
   output rsp_type             out_result
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_ALLOC  = 3'd3;
   localparam logic [2:0] ST_REPORT = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic [MAX_PARTITIONS-1:0] in_use_ff, in_use_in;
   logic [CNT_BITS-1:0]       rd_idx_ff, rd_idx_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic [IDX_BITS-1:0]       rd_tag_ff, rd_tag_in;
   logic                      found_ff, found_in;
   logic [IDX_BITS-1:0]       pick_ff, pick_in;
   logic [SIZE_BITS-1:0]      best_ff, best_in;
   logic [SIZE_BITS-1:0]      amount_ff, amount_in;

   logic                      ram_wr_en;
   logic [IDX_BITS-1:0]       ram_wr_addr;
   logic [RAM_W-1:0]          ram_wr_data;
   logic                      ram_rd_en;
   logic [IDX_BITS-1:0]       ram_rd_addr;
   logic [RAM_W-1:0]          ram_rd_data;

   logic [SIZE_BITS-1:0]      rd_size;
   logic [SIZE_BITS-1:0]      rd_left;
   logic [SIZE_BITS-1:0]      alloc_left;
   logic [CNT_BITS-1:0]       nxt_idx;
   logic                      accept;
   logic                      fits;
   logic                      take;
   logic                      rpt_last;

   pfa_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_PARTITIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign in_ready   = (state_ff == ST_IDLE);
   assign accept     = in_valid && in_ready;
   assign rd_size    = ram_rd_data[SIZE_BITS-1:0];
   assign rd_left    = ram_rd_data[RAM_W-1:SIZE_BITS];
   assign alloc_left = best_ff - amount_ff;
   assign nxt_idx    = rd_idx_ff + CNT_BITS'(1);
   assign rpt_last   = (nxt_idx == cnt_ff);
   assign fits       = !in_use_ff[rd_tag_ff] && (rd_size >= amount_ff);
   assign take       = fits && (!found_ff
                                || ((fit_policy == POL_BEST) && (rd_size < best_ff))
                                || ((fit_policy == POL_WORST) && (rd_size > best_ff)));

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      in_use_in   = in_use_ff;
      rd_idx_in   = rd_idx_ff;
      rd_valid_in = 1'b0;
      rd_tag_in   = rd_tag_ff;
      found_in    = found_ff;
      pick_in     = pick_ff;
      best_in     = best_ff;
      amount_in   = amount_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = cnt_ff[IDX_BITS-1:0];
      ram_wr_data = {amount_ff, amount_ff};
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_idx_ff[IDX_BITS-1:0];
      out_push    = 1'b0;
      out_result  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               amount_in = SIZE_BITS'(in_amount);
               rd_idx_in = '0;
               found_in  = 1'b0;
               case (in_action)
                  ACT_LOAD: begin
                     state_in = ST_LOAD;
                  end
                  ACT_ALLOC: begin
                     state_in = ST_SCAN;
                  end
                  ACT_REPORT: begin
                     if (cnt_ff != '0) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        state_in    = ST_REPORT;
                     end
                  end
                  default: begin
                     cnt_in    = '0;
                     in_use_in = '0;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            if (out_ready) begin
               out_push        = 1'b1;
               out_result.kind = KIND_LOAD;
               out_result.last = 1'b1;
               if (cnt_ff < CNT_BITS'(MAX_PARTITIONS)) begin
                  ram_wr_en                        = 1'b1;
                  in_use_in[cnt_ff[IDX_BITS-1:0]] = 1'b0;
                  cnt_in                           = cnt_ff + CNT_BITS'(1);
                  out_result.success               = 1'b1;
                  out_result.index                 = INDEX_W'(cnt_ff);
                  out_result.space                 = SPACE_W'(amount_ff);
               end
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff < cnt_ff) begin
               ram_rd_en   = 1'b1;
               rd_idx_in   = nxt_idx;
               rd_valid_in = 1'b1;
               rd_tag_in   = rd_idx_ff[IDX_BITS-1:0];
            end else if (!rd_valid_ff) begin
               state_in = ST_ALLOC;
            end
            if (rd_valid_ff && take) begin
               found_in = 1'b1;
               pick_in  = rd_tag_ff;
               best_in  = rd_size;
            end
         end
         ST_ALLOC: begin
            if (out_ready) begin
               out_push        = 1'b1;
               out_result.kind = KIND_ALLOC;
               out_result.last = 1'b1;
               if (found_ff) begin
                  ram_wr_en          = 1'b1;
                  ram_wr_addr        = pick_ff;
                  ram_wr_data        = {alloc_left, best_ff};
                  in_use_in[pick_ff] = 1'b1;
                  out_result.success = 1'b1;
                  out_result.index   = INDEX_W'(pick_ff);
                  out_result.space   = SPACE_W'(alloc_left);
               end
               state_in = ST_IDLE;
            end
         end
         ST_REPORT: begin
            if (out_ready) begin
               out_push           = 1'b1;
               out_result.kind    = KIND_REPORT;
               out_result.success = 1'b1;
               out_result.index   = INDEX_W'(rd_idx_ff);
               out_result.space   = SPACE_W'(rd_left);
               out_result.last    = rpt_last;
               if (rpt_last) begin
                  state_in = ST_IDLE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = nxt_idx[IDX_BITS-1:0];
                  rd_idx_in   = nxt_idx;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         in_use_ff   <= '0;
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         in_use_ff   <= in_use_in;
         rd_valid_ff <= rd_valid_in;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      rd_tag_ff <= rd_tag_in;
      pick_ff   <= pick_in;
      best_ff   <= best_in;
      amount_ff <= amount_in;
   end

`ifndef NO_ASSERTIONS
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> out_ready)
      else $error("result pushed into a full output stage");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(MAX_PARTITIONS))
      else $error("partition count beyond table depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && (in_action == ACT_CLEAR)) |=> ((cnt_ff == '0) && (in_use_ff == '0)))
      else $error("clear left entries behind");

   a_alloc_in_table: assert property (@(posedge clock) disable iff (reset)
      (out_push && (out_result.kind == KIND_ALLOC) && out_result.success)
         |-> ((CNT_BITS'(pick_ff) < cnt_ff) && !in_use_ff[pick_ff]))
      else $error("allocation picked a used or absent partition");
`endif

endmodule
